// File: rtl/rps_pkg.sv
// Shared types and constants for the ray position sequencer.
// Used by every module of the block; depends on nothing.
package rps_pkg;

  localparam int MaxRange = 31;
  localparam int RangeW = 5;
  localparam int QueueDepth = 2;

  // Configuration register indexes.
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegStepX = 3'd3;
  localparam logic [2:0] RegStepY = 3'd4;
  localparam logic [2:0] RegStepZ = 3'd5;

  // One classified request: closest index and both ranges.
  typedef struct packed {
    logic signed [34:0] q;
    logic [RangeW-1:0] fwd;
    logic [RangeW-1:0] back;
    logic far_first;
  } job_t;

endpackage

// File: rtl/ray_position_sequencer.sv
// A request passes the multiply, divide, rounding and range steps in the front, then the
// queue handoff and the offset walk in the back before its first result; distance limits
// add a range search, and each offset skipped before the first result delays it further.
// The front takes a new request only after handing off the last, so its divider and range
// search set the request rate; a two-entry queue lets the back emit up to 63 results per request meanwhile.
// Reset: synchronous rst clears control state and loads origin 0, step (1.0,0,0).
module ray_position_sequencer (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic signed [31:0] cam_z,
  input  logic far_first,
  input  logic limit_is_distance,
  input  logic [30:0] forward_limit,
  input  logic [30:0] back_limit,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic is_position,
  output logic last
);

  logic signed [31:0] org [3];
  logic signed [31:0] stp [3];
  logic fj_valid;
  logic fj_stall;
  rps_pkg::job_t fj;
  logic bj_valid;
  logic bj_stall;
  rps_pkg::job_t bj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      stp[0] <= 32'sh00010000;
      stp[1] <= '0;
      stp[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rps_pkg::RegOriginX: org[0] <= cfg_data;
        rps_pkg::RegOriginY: org[1] <= cfg_data;
        rps_pkg::RegOriginZ: org[2] <= cfg_data;
        rps_pkg::RegStepX: stp[0] <= cfg_data;
        rps_pkg::RegStepY: stp[1] <= cfg_data;
        rps_pkg::RegStepZ: stp[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rps_front u_front (
    .clk, .rst, .org, .stp, .in_valid, .in_stall, .cam_x, .cam_y, .cam_z,
    .far_first, .limit_is_distance, .forward_limit, .back_limit,
    .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
  );

  rps_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_job(fj),
    .rd_valid(bj_valid), .rd_stall(bj_stall), .rd_job(bj)
  );

  rps_back u_back (
    .clk, .rst, .org, .stp, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
    .out_valid, .out_stall, .pos_x, .pos_y, .pos_z, .is_position, .last
  );

endmodule

// File: rtl/rps_front.sv
// Front part: computes the closest step index and both ranges of one request.
// Uses rps_pkg; a sequencer runs a shared multiplier and a restoring divider.
module rps_front (
  input  logic clk,
  input  logic rst,
  input  logic signed [31:0] org [3],
  input  logic signed [31:0] stp [3],
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic signed [31:0] cam_z,
  input  logic far_first,
  input  logic limit_is_distance,
  input  logic [30:0] forward_limit,
  input  logic [30:0] back_limit,
  output logic job_valid,
  input  logic job_stall,
  output rps_pkg::job_t job
);

  localparam int RangeW_l = rps_pkg::RangeW;
  localparam int MaxRangeL = rps_pkg::MaxRange;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_RANGE, S_DONE} state_t;

  state_t state;
  logic [1:0] mcnt;
  logic [6:0] dcnt;
  logic [4:0] rk;
  logic rphase;
  logic signed [32:0] d [3];
  logic signed [67:0] acc;
  logic [65:0] den;
  logic [66:0] num;
  logic [66:0] rem;
  logic [36:0] quo;
  logic qsat;
  logic neg;
  logic lim_dist;
  logic [30:0] flim;
  logic [30:0] blim;
  logic [RangeW_l-1:0] fwd;
  logic [RangeW_l-1:0] back;
  logic ff;

  // Shared multiplier operands.
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mprod;
  logic [67:0] rsh;
  logic [67:0] rsub;
  logic [36:0] qbump;
  logic [61:0] l2;
  logic [10:0] kk;
  logic [71:0] lhs;
  logic [30:0] lim;
  logic [34:0] qmag;

  always_comb begin
    ma = d[mcnt];
    mb = 33'(stp[mcnt]);
    mprod = ma * mb;
    rsh = {rem, num[66]};
    rsub = rsh - {2'b0, den};
    qbump = quo + 37'd1;
    lim = rphase ? blim : flim;
    l2 = 62'(lim) * 62'(lim);
    kk = 11'(({6'b0, rk} + 11'd1) * ({6'b0, rk} + 11'd1));
    lhs = 72'(den) * 72'(kk);
    if (qsat || quo > 37'h200000000) qmag = 35'h200000000;
    else qmag = quo[34:0];
  end

  assign in_stall = (state != S_IDLE);
  assign job_valid = (state == S_DONE);
  assign job.q = neg ? -qmag : qmag;
  assign job.fwd = fwd;
  assign job.back = back;
  assign job.far_first = ff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            d[0] <= 33'(cam_x) - 33'(org[0]);
            d[1] <= 33'(cam_y) - 33'(org[1]);
            d[2] <= 33'(cam_z) - 33'(org[2]);
            ff <= far_first;
            lim_dist <= limit_is_distance;
            flim <= forward_limit;
            blim <= back_limit;
            acc <= '0;
            den <= '0;
            mcnt <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // Dot product and |step|^2 one component per cycle.
          acc <= acc + 68'(mprod);
          den <= den + 66'(64'(stp[mcnt] * stp[mcnt]));
          if (mcnt == 2'd2) begin
            state <= S_DIV;
            dcnt <= 7'd0;
            rem <= '0;
            quo <= '0;
            qsat <= 1'b0;
          end else begin
            mcnt <= mcnt + 2'd1;
          end
          if (mcnt == 2'd2) begin
            neg <= (acc + 68'(mprod)) < 0;
            num <= 67'((acc + 68'(mprod)) < 0 ? -(acc + 68'(mprod)) : (acc + 68'(mprod)));
          end
        end
        S_DIV: begin
          // One quotient bit per cycle.
          if (den == '0) begin
            quo <= '0;
            qsat <= 1'b0;
            neg <= 1'b0;
            state <= S_RANGE;
            rk <= '0;
            rphase <= 1'b0;
          end else begin
            num <= num << 1;
            if (!rsub[67]) begin
              rem <= rsub[66:0];
              if (!qsat) quo <= {quo[35:0], 1'b1};
              if (!qsat && {quo[35:0], 1'b1} >= 37'h800000000) qsat <= 1'b1;
            end else begin
              rem <= rsh[66:0];
              if (!qsat) quo <= {quo[35:0], 1'b0};
              if (!qsat && {quo[35:0], 1'b0} >= 37'h800000000) qsat <= 1'b1;
            end
            if (dcnt == 7'd66) begin
              state <= S_RANGE;
              rk <= '0;
              rphase <= 1'b0;
            end
            dcnt <= dcnt + 7'd1;
          end
          if (dcnt == 7'd67) begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (rk == '0 && !rphase && den != '0 && !qsat && dcnt == 7'd67
              && {rem, 1'b0} >= {2'b0, den}) begin
            quo <= qbump;
            dcnt <= 7'd0;
          end else if (rk == '0 && !rphase && dcnt == 7'd67) begin
            dcnt <= 7'd0;
          end else if (!lim_dist) begin
            fwd <= (flim > 31'(MaxRangeL)) ? RangeW_l'(MaxRangeL) : RangeW_l'(flim);
            back <= (blim > 31'(MaxRangeL)) ? RangeW_l'(MaxRangeL) : RangeW_l'(blim);
            state <= S_DONE;
          end else begin
            // Search one candidate range per cycle.
            if (rk == RangeW_l'(MaxRangeL) || lhs > 72'(l2)) begin
              if (!rphase) begin
                fwd <= rk;
                rphase <= 1'b1;
                rk <= '0;
              end else begin
                back <= rk;
                state <= S_DONE;
              end
            end else begin
              rk <= rk + 5'd1;
            end
          end
        end
        S_DONE: begin
          if (!job_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("front accepts while busy");
  a_done: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_stall |=> job_valid) else $error("job dropped");
  a_qcap: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (qmag <= 35'h200000000)) else $error("index over cap");
`endif

endmodule

// File: rtl/rps_queue.sv
// Short job queue between the front and back parts.
// Uses rps_pkg for the job type and depth.
module rps_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  rps_pkg::job_t wr_job,
  output logic rd_valid,
  input  logic rd_stall,
  output rps_pkg::job_t rd_job
);

  rps_pkg::job_t slot [rps_pkg::QueueDepth];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  logic push;
  logic pop;

  assign wr_stall = (cnt == 2'(rps_pkg::QueueDepth));
  assign rd_valid = (cnt != 2'd0);
  assign rd_job = slot[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wr_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'(rps_pkg::QueueDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> wp == rp) else $error("pointer mismatch");
  a_keep: assert property (@(posedge clk) disable iff (rst)
    rd_valid && rd_stall |=> rd_valid) else $error("entry lost");
`endif

endmodule

// File: rtl/rps_back.sv
// Back part: walks the offsets of one job and emits saturated positions or an empty-run marker.
// Uses rps_pkg; one offset per cycle while the output is not stalled, through a hold register and an output stage.
module rps_back (
  input  logic clk,
  input  logic rst,
  input  logic signed [31:0] org [3],
  input  logic signed [31:0] stp [3],
  input  logic job_valid,
  output logic job_stall,
  input  rps_pkg::job_t job,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic is_position,
  output logic last
);

  // Offset sequence walks idx 0..2*mx; near: 0,-1,+1,...; far reversed.
  logic busy;
  logic flush;
  logic [5:0] idx;
  logic [5:0] top;
  logic any;
  rps_pkg::job_t cur;
  logic signed [6:0] ofs;
  logic [5:0] sidx;
  logic [5:0] mx2;
  logic ok;
  logic signed [35:0] n;
  logic signed [32:0] nc;
  logic signed [66:0] pv [3];
  logic signed [31:0] ps [3];
  logic signed [31:0] hold [3];
  logic slot_free;
  logic adv;
  logic fin;
  logic emit_any;
  logic emit_last;

  always_comb begin
    mx2 = (cur.fwd > cur.back) ? {cur.fwd, 1'b0} : {cur.back, 1'b0};
    sidx = cur.far_first ? (mx2 - idx) : idx;
    if (sidx == 6'd0) ofs = '0;
    else if (sidx[0]) ofs = -7'(sidx[5:1]) - 7'sd1;
    else ofs = 7'(sidx[5:1]);
    ok = !(ofs > $signed({2'b0, cur.fwd}) || ofs < -$signed({2'b0, cur.back}));
    n = 36'(cur.q) + 36'(ofs);
    ok = ok && !n[35];
    if (n > 36'sh0FFFFFFFF) nc = 33'sh0FFFFFFFF;
    else nc = n[32:0];
    for (int i = 0; i < 3; i++) begin
      pv[i] = 67'(org[i]) + 67'(nc * 33'(stp[i]));
      if (pv[i] > 67'sh7FFFFFFF) ps[i] = 32'sh7FFFFFFF;
      else if (pv[i] < -67'sh80000000) ps[i] = 32'sh80000000;
      else ps[i] = pv[i][31:0];
    end
    slot_free = !out_valid || !out_stall;
    adv = busy && slot_free;
    fin = (idx == top);
    emit_any = adv && ok && any;
    emit_last = flush && slot_free;
  end

  assign job_stall = busy || flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      flush <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_any || emit_last || (out_valid && out_stall);
      if (!busy && !flush && job_valid) begin
        cur <= job;
        busy <= 1'b1;
        idx <= '0;
        any <= 1'b0;
        top <= (job.fwd > job.back) ? {job.fwd, 1'b0} : {job.back, 1'b0};
      end else if (adv) begin
        // Hold one pending position until the next passing offset shows it is not last.
        if (ok) begin
          if (any) begin
            pos_x <= hold[0];
            pos_y <= hold[1];
            pos_z <= hold[2];
            is_position <= 1'b1;
            last <= 1'b0;
          end
          hold[0] <= ps[0];
          hold[1] <= ps[1];
          hold[2] <= ps[2];
          any <= 1'b1;
        end
        if (fin) begin
          busy <= 1'b0;
          flush <= 1'b1;
        end
        idx <= idx + 6'd1;
      end else if (emit_last) begin
        // The held position, or the empty-run marker when none passed, closes the run.
        if (any) begin
          pos_x <= hold[0];
          pos_y <= hold[1];
          pos_z <= hold[2];
          is_position <= 1'b1;
        end else begin
          pos_x <= '0;
          pos_y <= '0;
          pos_z <= '0;
          is_position <= 1'b0;
        end
        last <= 1'b1;
        flush <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= top) else $error("offset walk overrun");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_take: assert property (@(posedge clk) disable iff (rst)
    busy |-> job_stall) else $error("job taken while busy");
`endif

endmodule

// File: tb/ray_position_sequencer_tb.sv
// Self-checking testbench for ray_position_sequencer: directed and random requests
// under several ray settings, checked against an in-bench predictor.
// Depends on rtl/rps_pkg.sv, rtl/ray_position_sequencer.sv, rtl/rps_front.sv, rtl/rps_queue.sv and rtl/rps_back.sv.
module ray_position_sequencer_tb;

  localparam logic [2:0] RegSpare6 = 3'd6;
  localparam logic [2:0] RegSpare7 = 3'd7;
  localparam int CycleLimit = 1000000;
  localparam int NumRegs = 6;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic is_pos;
    logic is_last;
  } position_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic far_first, limit_is_distance;
  logic [30:0] forward_limit, back_limit;
  logic out_valid, out_stall;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic is_position, last;

  ray_position_sequencer dut (.*);

  // Shadow copy of the ray registers and the positions still owed by the block.
  longint ray_regs [NumRegs];
  position_t pending_positions [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** ray_position_sequencer: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] clamp_pos(longint o, longint s, logic signed [127:0] n);
    logic signed [127:0] v;
    if (n > 128'sd4294967295) n = 128'sd4294967295;
    if (n < -128'sd4294967295) n = -128'sd4294967295;
    v = n * s;
    v = v + o;
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return v[31:0];
  endfunction

  function automatic int span_of(logic [30:0] lim, bit dist_mode, logic [127:0] den);
    logic [127:0] l2;
    logic [127:0] kk;
    int k;
    if (!dist_mode) return (lim > rps_pkg::MaxRange) ? rps_pkg::MaxRange : int'(lim);
    l2 = 128'(lim) * 128'(lim);
    k = 0;
    while (k < rps_pkg::MaxRange) begin
      kk = 128'(k + 1) * 128'(k + 1);
      if (den * kk > l2) break;
      k++;
    end
    return k;
  endfunction

  // Works out every position a request produces, in emission order.
  task automatic predict_positions(logic signed [31:0] cx, logic signed [31:0] cy,
                                   logic signed [31:0] cz, bit far, bit dist_mode,
                                   logic [30:0] fwd_lim, logic [30:0] back_lim);
    longint cam [3];
    logic signed [127:0] dot, term, absd, idx, quot, rem;
    logic [127:0] den;
    int fwd, back, top, ofs, cnt, i, j;
    position_t p;
    cam[0] = cx;
    cam[1] = cy;
    cam[2] = cz;
    dot = 0;
    den = 0;
    for (i = 0; i < 3; i++) begin
      term = cam[i] - ray_regs[i];
      dot = dot + term * ray_regs[3 + i];
      term = ray_regs[3 + i];
      den = den + 128'(term * term);
    end
    fwd = span_of(fwd_lim, dist_mode, den);
    back = span_of(back_lim, dist_mode, den);
    top = (fwd > back) ? fwd : back;
    if (den == 0) begin
      idx = 0;
    end else begin
      absd = (dot < 0) ? -dot : dot;
      quot = absd / $signed(den);
      rem = absd - quot * $signed(den);
      if (2 * rem >= $signed(den)) quot = quot + 1;
      if (quot > 128'sd8589934592) quot = 128'sd8589934592;
      idx = (dot < 0) ? -quot : quot;
    end
    cnt = 0;
    for (j = 0; j <= 2 * top; j++) begin
      // Near-first walks 0, -1, +1, ...; far-first is the exact reverse.
      i = far ? 2 * top - j : j;
      ofs = (i == 0) ? 0 : ((i % 2) ? -((i + 1) / 2) : i / 2);
      if (ofs > fwd || ofs < -back || idx + ofs < 0) continue;
      p.px = clamp_pos(ray_regs[0], ray_regs[3], idx + ofs);
      p.py = clamp_pos(ray_regs[1], ray_regs[4], idx + ofs);
      p.pz = clamp_pos(ray_regs[2], ray_regs[5], idx + ofs);
      p.is_pos = 1'b1;
      p.is_last = 1'b0;
      pending_positions.push_back(p);
      cnt++;
    end
    if (cnt == 0) begin
      p = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
      pending_positions.push_back(p);
    end else begin
      pending_positions[$].is_last = 1'b1;
    end
  endtask

  // Result side: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    position_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result pos=(%h %h %h) flag=%b last=%b",
                                         pos_x, pos_y, pos_z, is_position, last);
        end else begin
          want = pending_positions.pop_front();
          if (pos_x !== want.px || pos_y !== want.py || pos_z !== want.pz ||
              is_position !== want.is_pos || last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp (%h %h %h) flag=%b last=%b, got (%h %h %h) %b %b",
                       want.px, want.py, want.pz, want.is_pos, want.is_last,
                       pos_x, pos_y, pos_z, is_position, last);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, bit far,
                              bit dist_mode, logic [30:0] fwd_lim, logic [30:0] back_lim);
    in_valid <= 1'b1;
    cam_x <= cx;
    cam_y <= cy;
    cam_z <= cz;
    far_first <= far;
    limit_is_distance <= dist_mode;
    forward_limit <= fwd_lim;
    back_limit <= back_lim;
    do @(posedge clk); while (in_stall);
    predict_positions(cx, cy, cz, far, dist_mode, fwd_lim, back_lim);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index < NumRegs) ray_regs[index] = longint'($signed(data));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    wait_idle();
    write_reg(rps_pkg::RegOriginX, ox);
    write_reg(rps_pkg::RegOriginY, oy);
    write_reg(rps_pkg::RegOriginZ, oz);
    write_reg(rps_pkg::RegStepX, sx);
    write_reg(rps_pkg::RegStepY, sy);
    write_reg(rps_pkg::RegStepZ, sz);
  endtask

  // Directed cases, first under the reset ray (origin 0, step 1.0 along x), then under loaded rays.
  task automatic test_directed();
    write_reg(RegSpare6, 32'h1234_5678);
    write_reg(RegSpare7, 32'hffff_ffff);
    send_request(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 31'd3, 31'd3);
    send_request(32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 31'd3, 31'd3);
    // Half a step rounds away from zero in both directions.
    send_request(32'h0000_8000, 32'h0, 32'h0, 1'b0, 1'b0, 31'd2, 31'd2);
    send_request(32'hffff_8000, 32'h0, 32'h0, 1'b1, 1'b0, 31'd1, 31'd1);
    // All offsets fall before the origin, so only the empty marker comes back.
    send_request(32'hfff0_0000, 32'h0, 32'h0, 1'b0, 1'b0, 31'd3, 31'd3);
    send_request(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 31'd0, 31'd0);
    send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0,
                 31'h7fff_ffff, 31'h7fff_ffff);
    send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1,
                 31'h7fff_ffff, 31'h7fff_ffff);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1,
                 31'h7fff_ffff, 31'h7fff_ffff);
    send_request(32'h0005_0000, 32'h0, 32'h0, 1'b0, 1'b1, 31'h0001_ffff, 31'h0001_0000);
    send_request(32'h0005_0000, 32'h0, 32'h0, 1'b1, 1'b1, 31'h0000_7fff, 31'h0);
    send_request(32'h0005_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, 31'd40, 31'd5);
    // A tiny step pushes the index and the positions toward saturation.
    load_ray(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'h0, 32'h0);
    send_request(32'h7fff_ffff, 32'h0, 32'h0, 1'b0, 1'b0, 31'd31, 31'd31);
    send_request(32'h7fff_ffff, 32'h0, 32'h0, 1'b1, 1'b1, 31'd20, 31'd0);
    // Zero step vector: every position is the origin.
    load_ray(32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    send_request(32'h1234_5678, 32'h0, 32'h0, 1'b0, 1'b1, 31'd1, 31'd1);
    send_request(32'h1234_5678, 32'h0, 32'h0, 1'b1, 1'b0, 31'd2, 31'd0);
  endtask

  task automatic test_random(int count);
    logic signed [31:0] cam [3];
    logic signed [31:0] noise;
    longint t;
    bit far, dist_mode;
    logic [30:0] lim [2];
    int i, c, k;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) begin
        // Mostly near the ray, so the runs land on real positions.
        t = longint'($urandom_range(45)) - 5;
        for (c = 0; c < 3; c++) begin
          noise = $signed(32'($urandom_range(32'hffff))) - 32'sh8000;
          cam[c] = 32'(ray_regs[c] + t * ray_regs[3 + c]) + noise;
        end
      end else begin
        for (c = 0; c < 3; c++) cam[c] = $urandom;
      end
      far = 1'($urandom_range(1));
      dist_mode = 1'($urandom_range(1));
      for (k = 0; k < 2; k++) begin
        if (!dist_mode && $urandom_range(9) < 8) lim[k] = 31'($urandom_range(35));
        else lim[k] = 31'($urandom >> (1 + $urandom_range(31)));
        if ($urandom_range(19) == 0) lim[k] = 31'($urandom >> 1);
      end
      send_request(cam[0], cam[1], cam[2], far, dist_mode, lim[0], lim[1]);
    end
  endtask

  task automatic random_step(output logic [31:0] s);
    s = 32'($signed($urandom_range(32'h7ffff)) - 32'sh40000);
  endtask

  task automatic test_random_rays();
    logic [31:0] s [3];
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 85 : 0;
      recv_stall_pct = (phase < 2) ? 85 : (phase < 4) ? 6 : 0;
      case (phase)
        1: begin
          load_ray(32'h7fff_ffff, 32'h8000_0000, 32'h0,
                   32'h7fff_ffff, 32'h8000_0000, 32'h1);
        end
        3: begin
          load_ray($urandom, $urandom, $urandom, 32'h0, 32'h0, 32'h0);
        end
        default: begin
          random_step(s[0]);
          random_step(s[1]);
          random_step(s[2]);
          load_ray($urandom, $urandom, $urandom, s[0], s[1], s[2]);
        end
      endcase
      test_random((phase == 3) ? 20 : 38);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= rps_pkg::RegOriginX;
    cfg_data <= 32'h0;
    in_valid <= 1'b0;
    cam_x <= 32'h0;
    cam_y <= 32'h0;
    cam_z <= 32'h0;
    far_first <= 1'b0;
    limit_is_distance <= 1'b0;
    forward_limit <= 31'h0;
    back_limit <= 31'h0;
    foreach (ray_regs[i]) ray_regs[i] = 0;
    ray_regs[rps_pkg::RegStepX] = 65536;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_rays();
    wait_idle();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("** ray_position_sequencer: PASSED **");
    end else begin
      $display("** ray_position_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
